// ===== rtl/pebs_pkg.sv =====
// ----------------------------------------------------------------------------
// pebs_pkg
// Shared widths, register indexes, stage enable type and helpers for the
// particle euler bounce step core.
// ----------------------------------------------------------------------------
`default_nettype none

package pebs_pkg;

    localparam int COORD_BITS = 12;
    localparam int VEL_W      = 32;
    localparam int AGE_W      = 24;
    localparam int DT_W       = 24;
    localparam int DAMP_W     = 17;
    localparam int ALPHA_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // position sum: sign, coordinate and up to 24 bits of move
    localparam int POS_SUM_W  = 27;

    // pipeline depth in register stages
    localparam int DEPTH      = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFESPAN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;

    // reset values
    localparam logic [DT_W-1:0]       TIME_STEP_RST     = 24'd1092;
    localparam logic [AGE_W-1:0]      LIFESPAN_RST      = 24'd327680;
    localparam logic [DAMP_W-1:0]     DAMPING_GAIN_RST  = 17'd52429;
    localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RST  = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RST = COORD_BITS'(480);

    // one advance enable per pipeline stage
    typedef logic [DEPTH-1:0] stage_en_t;

    // finished motion of one particle
    typedef struct packed {
        logic [COORD_BITS-1:0]   pos_x;
        logic [COORD_BITS-1:0]   pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } kin_t;

    // saturate to signed 32 bits
    function automatic logic signed [VEL_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [VEL_W-1:0] r;
        if (x > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/particle_euler_bounce_step_core.sv =====
// ----------------------------------------------------------------------------
// particle_euler_bounce_step_core
// Semi-implicit Euler update of one particle per transaction with screen
// clamp, damped wall bounce, age advance and fade alpha.
// ----------------------------------------------------------------------------
// Throughput is one particle per clock while the result is not stalled; the
// pipeline depth is set by the eight-stage fade alpha divider that follows
// the age stages. The motion path (force product, velocity sum, move and
// damping products, clamp and bounce) is four stages and is delayed to line up
// with the alpha. Stages with no valid particle close up, so item_stall rises
// only when every stage is full and the result waits under result_stall.
// Configuration is written through cfg_valid/cfg_ready (always ready) and must
// be changed only while no particle is in flight.
`default_nettype none

module particle_euler_bounce_step_core (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,

    // particle input channel
    input  wire logic                                       item_valid,
    output logic                                            item_stall,
    input  wire logic [pebs_pkg::COORD_BITS-1:0]            pos_x,
    input  wire logic [pebs_pkg::COORD_BITS-1:0]            pos_y,
    input  wire logic signed [pebs_pkg::VEL_W-1:0]          vel_x,
    input  wire logic signed [pebs_pkg::VEL_W-1:0]          vel_y,
    input  wire logic signed [pebs_pkg::VEL_W-1:0]          force_x,
    input  wire logic signed [pebs_pkg::VEL_W-1:0]          force_y,
    input  wire logic [pebs_pkg::AGE_W-1:0]                 age_in,

    // result channel
    output logic                                            result_valid,
    input  wire logic                                       result_stall,
    output logic [pebs_pkg::COORD_BITS-1:0]                 new_pos_x,
    output logic [pebs_pkg::COORD_BITS-1:0]                 new_pos_y,
    output logic signed [pebs_pkg::VEL_W-1:0]               new_vel_x,
    output logic signed [pebs_pkg::VEL_W-1:0]               new_vel_y,
    output logic [pebs_pkg::AGE_W-1:0]                      new_age,
    output logic [pebs_pkg::ALPHA_W-1:0]                    fade_alpha,
    output logic                                            expired,

    // configuration write channel
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [pebs_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  wire logic [pebs_pkg::CFG_DATA_W-1:0]            cfg_data
);

    localparam int DEPTH    = pebs_pkg::DEPTH;
    localparam int AXIS_LAT = 4;
    localparam int DLY_N    = DEPTH - AXIS_LAT;

    // configuration registers
    logic [pebs_pkg::DT_W-1:0]        time_step_reg;
    logic [pebs_pkg::AGE_W-1:0]       lifespan_reg;
    logic [pebs_pkg::DAMP_W-1:0]      damping_gain_reg;
    logic [pebs_pkg::COORD_BITS-1:0]  screen_width_reg;
    logic [pebs_pkg::COORD_BITS-1:0]  screen_height_reg;

    // pipeline control
    logic [DEPTH-1:0]      valid_reg;
    pebs_pkg::stage_en_t   stage_en;
    logic                  item_take;

    // motion results and their delay line
    pebs_pkg::kin_t        kin_axis;
    pebs_pkg::kin_t        kin_dly_reg [0:DLY_N-1];

    assign cfg_ready = 1'b1;

    // config writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= pebs_pkg::TIME_STEP_RST;
            lifespan_reg      <= pebs_pkg::LIFESPAN_RST;
            damping_gain_reg  <= pebs_pkg::DAMPING_GAIN_RST;
            screen_width_reg  <= pebs_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= pebs_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pebs_pkg::REG_TIME_STEP:     time_step_reg     <= cfg_data[pebs_pkg::DT_W-1:0];
                pebs_pkg::REG_LIFESPAN:      lifespan_reg      <= cfg_data[pebs_pkg::AGE_W-1:0];
                pebs_pkg::REG_DAMPING_GAIN:  damping_gain_reg  <= cfg_data[pebs_pkg::DAMP_W-1:0];
                pebs_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[pebs_pkg::COORD_BITS-1:0];
                pebs_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[pebs_pkg::COORD_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        stage_en[DEPTH-1] = !valid_reg[DEPTH-1] || !result_stall;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
    end

    assign item_stall = !stage_en[0];
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= item_take;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
        end
    end

    // x bounded by the width, y by the height
    pebs_axis u_axis_x (
        .clk          (clk),
        .en           (stage_en),
        .pos          (pos_x),
        .vel          (vel_x),
        .force_in     (force_x),
        .time_step    (time_step_reg),
        .damping_gain (damping_gain_reg),
        .bound        (screen_width_reg),
        .pos_out      (kin_axis.pos_x),
        .vel_out      (kin_axis.vel_x)
    );

    pebs_axis u_axis_y (
        .clk          (clk),
        .en           (stage_en),
        .pos          (pos_y),
        .vel          (vel_y),
        .force_in     (force_y),
        .time_step    (time_step_reg),
        .damping_gain (damping_gain_reg),
        .bound        (screen_height_reg),
        .pos_out      (kin_axis.pos_y),
        .vel_out      (kin_axis.vel_y)
    );

    // age, expiry and alpha
    pebs_fade u_fade (
        .clk        (clk),
        .en         (stage_en),
        .age_in     (age_in),
        .time_step  (time_step_reg),
        .lifespan   (lifespan_reg),
        .new_age    (new_age),
        .fade_alpha (fade_alpha),
        .expired    (expired)
    );

    // hold motion results until the alpha catches up
    always_ff @(posedge clk)
    begin
        if (stage_en[AXIS_LAT])
        begin
            kin_dly_reg[0] <= kin_axis;
        end
        for (int i = 1; i < DLY_N; i++)
        begin
            if (stage_en[AXIS_LAT + i])
            begin
                kin_dly_reg[i] <= kin_dly_reg[i - 1];
            end
        end
    end

    assign result_valid = valid_reg[DEPTH-1];
    assign new_pos_x    = kin_dly_reg[DLY_N-1].pos_x;
    assign new_pos_y    = kin_dly_reg[DLY_N-1].pos_y;
    assign new_vel_x    = kin_dly_reg[DLY_N-1].vel_x;
    assign new_vel_y    = kin_dly_reg[DLY_N-1].vel_y;

    // input is held back only when every stage is full and the output waits
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> ((&valid_reg) && result_stall))
        else $error("input stalled with room in the pipeline");

    // an expired particle is fully transparent
    a_dead_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && expired) |-> (fade_alpha == '0))
        else $error("expired particle with nonzero alpha");

    // a particle in the next to last stage reaches the output when it moves
    a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[DEPTH-2] && stage_en[DEPTH-1]) |=> result_valid)
        else $error("particle lost before the output stage");

endmodule

`default_nettype wire

// ===== rtl/pebs_axis.sv =====
// ----------------------------------------------------------------------------
// pebs_axis
// One axis of the particle update over four stages: force times time step,
// velocity sum, move and damping products, then clamp and bounce.
// ----------------------------------------------------------------------------
`default_nettype none

module pebs_axis (
    input  wire logic                                   clk,
    input  wire pebs_pkg::stage_en_t                    en,
    input  wire logic [pebs_pkg::COORD_BITS-1:0]        pos,
    input  wire logic signed [pebs_pkg::VEL_W-1:0]      vel,
    input  wire logic signed [pebs_pkg::VEL_W-1:0]      force_in,
    input  wire logic [pebs_pkg::DT_W-1:0]              time_step,
    input  wire logic [pebs_pkg::DAMP_W-1:0]            damping_gain,
    input  wire logic [pebs_pkg::COORD_BITS-1:0]        bound,
    output logic [pebs_pkg::COORD_BITS-1:0]             pos_out,
    output logic signed [pebs_pkg::VEL_W-1:0]           vel_out
);

    localparam int CB = pebs_pkg::COORD_BITS;
    localparam int PW = pebs_pkg::POS_SUM_W;

    // stage 1
    logic signed [56:0]        accel_reg;
    logic signed [31:0]        vel_s1_reg;
    logic [CB-1:0]             pos_s1_reg;
    // stage 2
    logic signed [31:0]        vel_s2_reg;
    logic [CB-1:0]             pos_s2_reg;
    // stage 3
    logic signed [56:0]        move_reg;
    logic signed [49:0]        damp_prod_reg;
    logic signed [31:0]        vel_s3_reg;
    logic [CB-1:0]             pos_s3_reg;
    // stage 4
    logic [CB-1:0]             pos_s4_reg;
    logic signed [31:0]        vel_s4_reg;

    logic signed [41:0]        vel_sum;
    logic signed [56:0]        move_bias;
    logic signed [24:0]        move_px;
    logic signed [PW-1:0]      pos_sum;
    logic signed [PW-1:0]      bound_ext;
    logic                      low_hit;
    logic                      high_hit;
    logic signed [50:0]        bounce_neg;
    logic signed [34:0]        bounce_shr;
    logic signed [31:0]        bounce_vel;
    logic [CB-1:0]             pos_next;
    logic signed [31:0]        vel_next;

    always_comb
    begin
        vel_sum   = 42'(vel_s1_reg) + 42'(accel_reg >>> 16);

        // move truncated toward zero
        move_bias = move_reg[56] ? move_reg + 57'sd4294967295 : move_reg;
        move_px   = 25'(move_bias >>> 32);
        pos_sum   = PW'($signed({1'b0, pos_s3_reg})) + PW'(move_px);
        bound_ext = PW'($signed({1'b0, bound}));
        low_hit   = (pos_sum <= 0);
        high_hit  = (pos_sum >= bound_ext);

        // reflected velocity scaled by damping, floored
        bounce_neg = -(51'(damp_prod_reg));
        bounce_shr = 35'(bounce_neg >>> 16);
        bounce_vel = pebs_pkg::sat32(64'(bounce_shr));

        if (low_hit)
        begin
            pos_next = '0;
        end
        else if (high_hit)
        begin
            pos_next = bound;
        end
        else
        begin
            pos_next = pos_sum[CB-1:0];
        end
        vel_next = (low_hit || high_hit) ? bounce_vel : vel_s3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            accel_reg  <= force_in * $signed({1'b0, time_step});
            vel_s1_reg <= vel;
            pos_s1_reg <= pos;
        end
        if (en[1])
        begin
            vel_s2_reg <= pebs_pkg::sat32(64'(vel_sum));
            pos_s2_reg <= pos_s1_reg;
        end
        if (en[2])
        begin
            move_reg      <= vel_s2_reg * $signed({1'b0, time_step});
            damp_prod_reg <= vel_s2_reg * $signed({1'b0, damping_gain});
            vel_s3_reg    <= vel_s2_reg;
            pos_s3_reg    <= pos_s2_reg;
        end
        if (en[3])
        begin
            pos_s4_reg <= pos_next;
            vel_s4_reg <= vel_next;
        end
    end

    assign pos_out = pos_s4_reg;
    assign vel_out = vel_s4_reg;

endmodule

`default_nettype wire

// ===== rtl/pebs_fade.sv =====
// ----------------------------------------------------------------------------
// pebs_fade
// Age advance, expiry test and fade alpha, the alpha from a restoring divider
// that settles one quotient bit per stage over eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pebs_fade (
    input  wire logic                               clk,
    input  wire pebs_pkg::stage_en_t                en,
    input  wire logic [pebs_pkg::AGE_W-1:0]         age_in,
    input  wire logic [pebs_pkg::DT_W-1:0]          time_step,
    input  wire logic [pebs_pkg::AGE_W-1:0]         lifespan,
    output logic [pebs_pkg::AGE_W-1:0]              new_age,
    output logic [pebs_pkg::ALPHA_W-1:0]            fade_alpha,
    output logic                                    expired
);

    localparam int AW = pebs_pkg::AGE_W;
    localparam int QW = pebs_pkg::ALPHA_W;

    logic [AW:0]     age_sum;
    logic [AW-1:0]   age_s1_reg;
    logic            dead_s1;
    logic [AW-1:0]   life_left;

    // index 0 is stage 2, index 8 is the last stage
    logic [31:0]     rem_reg  [0:QW];
    logic [QW-1:0]   quot_reg [0:QW];
    logic            dead_reg [0:QW];
    logic [AW-1:0]   age_reg  [0:QW];

    always_comb
    begin
        age_sum   = {1'b0, age_in} + {1'b0, time_step};
        dead_s1   = (age_s1_reg >= lifespan);
        life_left = lifespan - age_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            age_s1_reg <= age_sum[AW] ? '1 : age_sum[AW-1:0];
        end
        if (en[1])
        begin
            // 255 * remaining life
            rem_reg[0]  <= dead_s1 ? 32'd0 : 32'({life_left, 8'd0}) - 32'(life_left);
            quot_reg[0] <= '0;
            dead_reg[0] <= dead_s1;
            age_reg[0]  <= age_s1_reg;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int SH = QW - 1 - s;
        logic [31:0] divisor;
        logic        take;

        always_comb
        begin
            divisor = 32'(lifespan) << SH;
            take    = (rem_reg[s] >= divisor);
        end

        always_ff @(posedge clk)
        begin
            if (en[s + 2])
            begin
                rem_reg[s + 1]  <= take ? rem_reg[s] - divisor : rem_reg[s];
                quot_reg[s + 1] <= {quot_reg[s][QW-2:0], take};
                dead_reg[s + 1] <= dead_reg[s];
                age_reg[s + 1]  <= age_reg[s];
            end
        end
    end

    assign new_age    = age_reg[QW];
    assign expired    = dead_reg[QW];
    assign fade_alpha = dead_reg[QW] ? '0 : quot_reg[QW];

endmodule

`default_nettype wire

// ===== test/particle_euler_bounce_step_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_bounce_step_core_tb
// Self-checking bench for the particle step core: a short table of directed
// particles and register writes, then random particle streams under a series
// of register settings, checked against table frames or a local predictor.
// ----------------------------------------------------------------------------

module particle_euler_bounce_step_core_tb;

    localparam int COORD_BITS = pebs_pkg::COORD_BITS;
    localparam int VEL_W      = pebs_pkg::VEL_W;
    localparam int AGE_W      = pebs_pkg::AGE_W;
    localparam int DT_W       = pebs_pkg::DT_W;
    localparam int DAMP_W     = pebs_pkg::DAMP_W;
    localparam int ALPHA_W    = pebs_pkg::ALPHA_W;
    localparam int CFG_IDX_W  = pebs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pebs_pkg::CFG_DATA_W;
    localparam int DEPTH      = pebs_pkg::DEPTH;

    // register indexes with no register behind them, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int RANDOM_PHASES       = 8;
    localparam int PARTICLES_PER_PHASE = 205;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7fffffff;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh80000000;
    localparam logic [AGE_W-1:0]        AGE_TOP = {AGE_W{1'b1}};

    // one particle entering the core
    typedef struct {
        logic [COORD_BITS-1:0]   pos_x;
        logic [COORD_BITS-1:0]   pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] force_x;
        logic signed [VEL_W-1:0] force_y;
        logic [AGE_W-1:0]        age;
    } particle_t;

    // the particle after one frame
    typedef struct {
        logic [COORD_BITS-1:0]   pos_x;
        logic [COORD_BITS-1:0]   pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [AGE_W-1:0]        age;
        logic [ALPHA_W-1:0]      alpha;
        logic                    expired;
    } frame_t;

    // directed table entry: either a register write or a particle
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        particle_t             pt;
        bit                    has_want;
        frame_t                want;
    } row_t;

    logic                           clk;
    logic                           rst_n;

    logic                           item_valid;
    logic                           item_stall;
    logic [COORD_BITS-1:0]          pos_x;
    logic [COORD_BITS-1:0]          pos_y;
    logic signed [VEL_W-1:0]        vel_x;
    logic signed [VEL_W-1:0]        vel_y;
    logic signed [VEL_W-1:0]        force_x;
    logic signed [VEL_W-1:0]        force_y;
    logic [AGE_W-1:0]               age_in;

    logic                           result_valid;
    logic                           result_stall;
    logic [COORD_BITS-1:0]          new_pos_x;
    logic [COORD_BITS-1:0]          new_pos_y;
    logic signed [VEL_W-1:0]        new_vel_x;
    logic signed [VEL_W-1:0]        new_vel_y;
    logic [AGE_W-1:0]               new_age;
    logic [ALPHA_W-1:0]             fade_alpha;
    logic                           expired;

    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index;
    logic [CFG_DATA_W-1:0]          cfg_data;

    // shadow copy of the register file as the predictor sees it
    logic [DT_W-1:0]                step_reg;
    logic [AGE_W-1:0]               life_reg;
    logic [DAMP_W-1:0]              damp_reg;
    logic [COORD_BITS-1:0]          width_reg;
    logic [COORD_BITS-1:0]          height_reg;

    // frames predicted for accepted particles, oldest first
    frame_t                         pending_frames[$];
    row_t                           directed_rows[$];

    // per-phase switches that turn off random gaps on either side
    bit                             tx_quiet;
    bit                             rx_quiet;

    int                             errors;
    int                             particles_sent;
    int                             directed_sent;
    int                             results_seen;
    int                             expired_seen;
    int                             reg_writes;

    particle_euler_bounce_step_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .force_x      (force_x),
        .force_y      (force_y),
        .age_in       (age_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_pos_x    (new_pos_x),
        .new_pos_y    (new_pos_y),
        .new_vel_x    (new_vel_x),
        .new_vel_y    (new_vel_y),
        .new_age      (new_age),
        .fade_alpha   (fade_alpha),
        .expired      (expired),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #2_000_000;
        $display("timeout with %0d frames still pending", pending_frames.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // frame predictor
    // ------------------------------------------------------------------------

    // clip a wide value to the signed 32 bit velocity range
    function automatic logic signed [VEL_W-1:0] clip_vel(input longint x);
        if (x > 64'sd2147483647)
        begin
            return VEL_MAX;
        end
        if (x < -64'sd2147483648)
        begin
            return VEL_MIN;
        end
        return x[VEL_W-1:0];
    endfunction

    // one axis: kick velocity by force, drift position, clamp and bounce
    function automatic void advance_axis(
        input  logic [COORD_BITS-1:0]   pos,
        input  logic signed [VEL_W-1:0] vel,
        input  logic signed [VEL_W-1:0] frc,
        input  logic [COORD_BITS-1:0]   edge_px,
        output logic [COORD_BITS-1:0]   pos_o,
        output logic signed [VEL_W-1:0] vel_o
    );
        longint dt;
        longint gain;
        longint lim;
        longint v;
        longint p;
        longint drift;
        dt   = step_reg;
        gain = damp_reg;
        lim  = edge_px;
        p    = pos;
        v    = vel;
        // velocity first, force product floored
        v = clip_vel(v + ((longint'(frc) * dt) >>> 16));
        // drift truncates toward zero
        drift = v * dt;
        drift = (drift < 0) ? -((-drift) >>> 32) : (drift >>> 32);
        p = p + drift;
        // a coordinate landing exactly on zero counts as a wall hit too
        if (p >= lim || p <= 0)
        begin
            if (p <= 0 && lim > 0)
            begin
                p = 0;
            end
            else if (p >= lim)
            begin
                p = lim;
            end
            else
            begin
                p = 0;
            end
            v = clip_vel((-v * gain) >>> 16);
        end
        pos_o = p[COORD_BITS-1:0];
        vel_o = v[VEL_W-1:0];
    endfunction

    function automatic frame_t predict_frame(input particle_t pt);
        frame_t           f;
        logic [AGE_W:0]   age_sum;
        longint           left;
        advance_axis(pt.pos_x, pt.vel_x, pt.force_x, width_reg, f.pos_x, f.vel_x);
        advance_axis(pt.pos_y, pt.vel_y, pt.force_y, height_reg, f.pos_y, f.vel_y);
        age_sum = pt.age + step_reg;
        if (age_sum > {1'b0, AGE_TOP})
        begin
            age_sum = {1'b0, AGE_TOP};
        end
        f.age     = age_sum[AGE_W-1:0];
        f.expired = (f.age >= life_reg);
        f.alpha   = '0;
        if (!f.expired && life_reg != 0)
        begin
            left    = life_reg;
            left    = (255 * (left - longint'(f.age))) / longint'(life_reg);
            f.alpha = left[ALPHA_W-1:0];
        end
        return f;
    endfunction

    // mirror of a register write; unknown indexes leave everything alone
    function automatic void note_reg_write(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        case (idx)
            pebs_pkg::REG_TIME_STEP:     step_reg   = data[DT_W-1:0];
            pebs_pkg::REG_LIFESPAN:      life_reg   = data[AGE_W-1:0];
            pebs_pkg::REG_DAMPING_GAIN:  damp_reg   = data[DAMP_W-1:0];
            pebs_pkg::REG_SCREEN_WIDTH:  width_reg  = data[COORD_BITS-1:0];
            pebs_pkg::REG_SCREEN_HEIGHT: height_reg = data[COORD_BITS-1:0];
            default:                     ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // random particle content
    // ------------------------------------------------------------------------

    // coordinates cluster around the walls and the far corner
    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] edge_px);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return edge_px;
            2:       return edge_px - 1'b1;
            3:       return edge_px + 1'b1;
            4:       return {COORD_BITS{1'b1}};
            5, 6:    return COORD_BITS'($urandom);
            default: return COORD_BITS'($urandom_range(0, edge_px));
        endcase
    endfunction

    // q16.16 value, mostly within +-span pixels, sometimes extreme or raw
    function automatic logic signed [VEL_W-1:0] pick_q16(input int span);
        case ($urandom_range(0, 11))
            0:       return VEL_MAX;
            1:       return VEL_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return $urandom;
            default: return int'($urandom_range(0, 2 * span * 65536)) - span * 65536;
        endcase
    endfunction

    // ages gather around the expiry threshold
    function automatic logic [AGE_W-1:0] pick_age();
        case ($urandom_range(0, 7))
            0:       return AGE_TOP;
            1:       return '0;
            2:       return AGE_W'($urandom);
            3:       return life_reg - step_reg;
            4:       return life_reg - step_reg - 1'b1;
            default: return (life_reg == 0) ? AGE_W'($urandom)
                                            : AGE_W'($urandom_range(0, life_reg));
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t pt;
        pt.pos_x   = pick_coord(width_reg);
        pt.pos_y   = pick_coord(height_reg);
        pt.vel_x   = pick_q16(600);
        pt.vel_y   = pick_q16(600);
        pt.force_x = pick_q16(4000);
        pt.force_y = pick_q16(4000);
        pt.age     = pick_age();
        return pt;
    endfunction

    // ------------------------------------------------------------------------
    // directed table builders
    // ------------------------------------------------------------------------

    function automatic row_t particle_row(
        input logic [COORD_BITS-1:0]   px,
        input logic [COORD_BITS-1:0]   py,
        input logic signed [VEL_W-1:0] vx,
        input logic signed [VEL_W-1:0] vy,
        input logic signed [VEL_W-1:0] fx,
        input logic signed [VEL_W-1:0] fy,
        input logic [AGE_W-1:0]        age
    );
        row_t r;
        r.is_reg     = 1'b0;
        r.has_want   = 1'b0;
        r.pt.pos_x   = px;
        r.pt.pos_y   = py;
        r.pt.vel_x   = vx;
        r.pt.vel_y   = vy;
        r.pt.force_x = fx;
        r.pt.force_y = fy;
        r.pt.age     = age;
        return r;
    endfunction

    // attach a hand-computed frame to a particle row
    function automatic row_t known(
        input row_t                    r,
        input logic [COORD_BITS-1:0]   px,
        input logic [COORD_BITS-1:0]   py,
        input logic signed [VEL_W-1:0] vx,
        input logic signed [VEL_W-1:0] vy,
        input logic [AGE_W-1:0]        age,
        input logic [ALPHA_W-1:0]      alpha,
        input logic                    dead
    );
        r.has_want     = 1'b1;
        r.want.pos_x   = px;
        r.want.pos_y   = py;
        r.want.vel_x   = vx;
        r.want.vel_y   = vy;
        r.want.age     = age;
        r.want.alpha   = alpha;
        r.want.expired = dead;
        return r;
    endfunction

    function automatic row_t reg_row(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        row_t r;
        r.is_reg   = 1'b1;
        r.has_want = 1'b0;
        r.idx      = idx;
        r.data     = data;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------------

    // cfg_valid is left high after the write so that back-to-back writes never
    // lower and raise it in one step; the next particle lowers it
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        note_reg_write(idx, data);
        reg_writes++;
    endtask

    // present one particle after a random gap and hold it until taken
    task automatic send_particle(input particle_t pt, input frame_t want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        cfg_valid <= 1'b0;
        repeat (gap)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        pos_x      <= pt.pos_x;
        pos_y      <= pt.pos_y;
        vel_x      <= pt.vel_x;
        vel_y      <= pt.vel_y;
        force_x    <= pt.force_x;
        force_y    <= pt.force_y;
        age_in     <= pt.age;
        do
            @(posedge clk);
        while (item_stall);
        pending_frames.push_back(want);
        particles_sent++;
    endtask

    // stop sending and let every frame in flight come back
    task automatic wait_idle();
        if (item_valid)
        begin
            item_valid <= 1'b0;
        end
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // register settings for the random phases: reset values, then extremes
    task automatic program_phase(input int ph);
        logic [CFG_DATA_W-1:0] ts;
        logic [CFG_DATA_W-1:0] life;
        logic [CFG_DATA_W-1:0] gain;
        logic [CFG_DATA_W-1:0] wid;
        logic [CFG_DATA_W-1:0] hgt;
        wait_idle();
        case (ph)
            0:
            begin
                ts   = CFG_DATA_W'(pebs_pkg::TIME_STEP_RST);
                life = CFG_DATA_W'(pebs_pkg::LIFESPAN_RST);
                gain = CFG_DATA_W'(pebs_pkg::DAMPING_GAIN_RST);
                wid  = CFG_DATA_W'(pebs_pkg::SCREEN_WIDTH_RST);
                hgt  = CFG_DATA_W'(pebs_pkg::SCREEN_HEIGHT_RST);
            end
            1:
            begin
                // frozen time, longest life, dead stop on bounce, largest screen
                ts   = '0;
                life = {CFG_DATA_W{1'b1}};
                gain = '0;
                wid  = CFG_DATA_W'(4095);
                hgt  = CFG_DATA_W'(4095);
            end
            2:
            begin
                // longest step, shortest life, top gain, one-pixel screen
                ts   = {CFG_DATA_W{1'b1}};
                life = CFG_DATA_W'(1);
                gain = CFG_DATA_W'(17'h1ffff);
                wid  = CFG_DATA_W'(1);
                hgt  = CFG_DATA_W'(1);
            end
            3:
            begin
                // zero lifespan and zero-size screen, gain of exactly one
                ts   = CFG_DATA_W'($urandom_range(1, 8192));
                life = '0;
                gain = CFG_DATA_W'(65536);
                wid  = '0;
                hgt  = '0;
            end
            default:
            begin
                // raw 24 bit data now and then so the masked upper bits toggle
                ts   = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(1, 8192));
                life = CFG_DATA_W'($urandom_range(1, 24'hffffff));
                gain = CFG_DATA_W'(($urandom_range(0, 1) == 0) ? $urandom
                                                               : $urandom_range(0, 65536));
                wid  = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(1, 4095));
                hgt  = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                               : $urandom_range(1, 4095));
            end
        endcase
        write_reg(pebs_pkg::REG_TIME_STEP, ts);
        write_reg(pebs_pkg::REG_LIFESPAN, life);
        write_reg(pebs_pkg::REG_DAMPING_GAIN, gain);
        write_reg(pebs_pkg::REG_SCREEN_WIDTH, wid);
        write_reg(pebs_pkg::REG_SCREEN_HEIGHT, hgt);
        write_reg((ph % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(
        input string             name,
        input logic signed [63:0] want_v,
        input logic signed [63:0] got_v
    );
        if (want_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endfunction

    // result side: random stall before each transaction, then take the
    // next valid frame and compare it with the oldest prediction
    initial
    begin : result_sink
        frame_t want;
        int     hold;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 4);
            repeat (hold)
            begin
                result_stall <= 1'b1;
                @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (result_valid !== 1'b1);
            results_seen++;
            if (pending_frames.size() == 0)
            begin
                errors++;
                $display("%0t: result transaction with no particle outstanding", $time);
            end
            else
            begin
                want = pending_frames.pop_front();
                compare_field("new_pos_x", want.pos_x, new_pos_x);
                compare_field("new_pos_y", want.pos_y, new_pos_y);
                compare_field("new_vel_x", want.vel_x, new_vel_x);
                compare_field("new_vel_y", want.vel_y, new_vel_y);
                compare_field("new_age", want.age, new_age);
                compare_field("fade_alpha", want.alpha, fade_alpha);
                compare_field("expired", want.expired, expired);
                if (want.expired)
                begin
                    expired_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        particle_t pt;
        frame_t    want;

        // every input known from time zero
        rst_n      = 1'b0;
        item_valid = 1'b0;
        pos_x      = '0;
        pos_y      = '0;
        vel_x      = '0;
        vel_y      = '0;
        force_x    = '0;
        force_y    = '0;
        age_in     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        errors         = 0;
        particles_sent = 0;
        directed_sent  = 0;
        results_seen   = 0;
        expired_seen   = 0;
        reg_writes     = 0;

        step_reg   = pebs_pkg::TIME_STEP_RST;
        life_reg   = pebs_pkg::LIFESPAN_RST;
        damp_reg   = pebs_pkg::DAMPING_GAIN_RST;
        width_reg  = pebs_pkg::SCREEN_WIDTH_RST;
        height_reg = pebs_pkg::SCREEN_HEIGHT_RST;

        // reset register values: still particle, moving only in age
        directed_rows.push_back(known(particle_row(100, 100, 0, 0, 0, 0, 0),
                                      100, 100, 0, 0, 1092, 254, 1'b0));
        // resting exactly on zero is a wall hit
        directed_rows.push_back(known(particle_row(0, 0, 0, 0, 0, 0, 0),
                                      0, 0, 0, 0, 1092, 254, 1'b0));
        // far corner clamps onto both edges
        directed_rows.push_back(known(particle_row(4095, 4095, 0, 0, 0, 0, 0),
                                      640, 480, 0, 0, 1092, 254, 1'b0));
        // age saturates at the top of its range
        directed_rows.push_back(known(particle_row(100, 100, 0, 0, 0, 0, AGE_TOP),
                                      100, 100, 0, 0, AGE_TOP, 0, 1'b1));
        // age lands exactly on the lifespan
        directed_rows.push_back(known(particle_row(100, 100, 0, 0, 0, 0, 326588),
                                      100, 100, 0, 0, 327680, 0, 1'b1));
        // one tick short of the lifespan, alpha already rounds to zero
        directed_rows.push_back(known(particle_row(100, 100, 0, 0, 0, 0, 326587),
                                      100, 100, 0, 0, 327679, 0, 1'b0));
        // velocity overflow in both directions
        directed_rows.push_back(particle_row(320, 240, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, 0));
        directed_rows.push_back(particle_row(320, 240, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MIN, 1000));
        // bounce off the far walls and off the near walls
        directed_rows.push_back(particle_row(639, 479, 32'sd19660800, 32'sd19660800, 0, 0, 0));
        directed_rows.push_back(particle_row(1, 1, -32'sd19660800, -32'sd19660800, 0, 0, 0));
        directed_rows.push_back(particle_row(12'haaa, 12'h555, -32'sd1, 32'sd1,
                                             32'sh55555555, 32'shaaaaaaaa, 24'h800000));
        // longest time step
        directed_rows.push_back(reg_row(pebs_pkg::REG_TIME_STEP, {CFG_DATA_W{1'b1}}));
        directed_rows.push_back(particle_row(2048, 2048, 32'sd65536, -32'sd65536, 0, 0, 0));
        directed_rows.push_back(particle_row(10, 10, 0, 0, VEL_MAX, VEL_MIN, 0));
        // damping gain above one grows the velocity until it saturates
        directed_rows.push_back(reg_row(pebs_pkg::REG_DAMPING_GAIN, 24'h01ffff));
        directed_rows.push_back(reg_row(REG_SPARE_HI, {CFG_DATA_W{1'b1}}));
        directed_rows.push_back(particle_row(4000, 4000, VEL_MAX, VEL_MAX, 0, 0, 0));
        directed_rows.push_back(particle_row(5, 5, VEL_MIN, VEL_MIN, 0, 0, 0));
        // zero-size screen pins everything to the origin
        directed_rows.push_back(reg_row(pebs_pkg::REG_SCREEN_WIDTH, '0));
        directed_rows.push_back(reg_row(pebs_pkg::REG_SCREEN_HEIGHT, '0));
        directed_rows.push_back(known(particle_row(100, 100, 0, 0, 0, 0, 0),
                                      0, 0, 0, 0, AGE_TOP, 0, 1'b1));
        // zero lifespan: always expired
        directed_rows.push_back(reg_row(pebs_pkg::REG_LIFESPAN, '0));
        directed_rows.push_back(reg_row(pebs_pkg::REG_TIME_STEP, '0));
        directed_rows.push_back(known(particle_row(7, 9, 0, 0, 0, 0, 0),
                                      0, 0, 0, 0, 0, 0, 1'b1));
        directed_rows.push_back(particle_row(4095, 4095, 32'sd3276800, -32'sd3276800,
                                             VEL_MAX, VEL_MIN, 24'h123456));
        directed_rows.push_back(reg_row(REG_SPARE_LO, 24'h5a5a5a));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: registers change only with nothing in flight
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                if (directed_rows[i].has_want)
                begin
                    want = directed_rows[i].want;
                end
                else
                begin
                    want = predict_frame(directed_rows[i].pt);
                end
                send_particle(directed_rows[i].pt, want);
                directed_sent++;
            end
        end

        // random streams, one register setting per phase; two phases run
        // with no gaps on the sender, two with no stalls on the receiver
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_phase(ph);
            tx_quiet = (ph == 2 || ph == 5);
            rx_quiet = (ph == 5 || ph == 6);
            for (int n = 0; n < PARTICLES_PER_PHASE; n++)
            begin
                // let the pipeline run dry once in the middle of a stream
                if (ph == 4 && n == PARTICLES_PER_PHASE / 2)
                begin
                    wait_idle();
                end
                pt = rand_particle();
                send_particle(pt, predict_frame(pt));
            end
        end

        // drain, then watch a while longer for stray results
        wait_idle();
        repeat (2 * DEPTH) @(posedge clk);

        $display("covered %0d particles (%0d from the table) across %0d register writes",
                 particles_sent, directed_sent, reg_writes);
        $display("compared %0d frames, %0d of them expired", results_seen, expired_seen);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== particle_euler_bounce_step_core.f =====
rtl/pebs_pkg.sv
rtl/pebs_axis.sv
rtl/pebs_fade.sv
rtl/particle_euler_bounce_step_core.sv
test/particle_euler_bounce_step_core_tb.sv
